@@ rtl/core/sorted_trimmed_mean_filter_core_assert.svh @@
// Assertion macros used by the filter core back end.
`ifndef SORTED_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH
`define SORTED_TRIMMED_MEAN_FILTER_CORE_ASSERT_SVH
// Same-cycle implication, checked on clk and masked during reset.
`define STMF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on clk and masked during reset.
`define STMF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/stmf_pkg.sv @@
// Package: payload types, configuration codes and status codes of the filter core.
`timescale 1ns / 1ps
package stmf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int STATUS_W = 2;
    localparam int TRIM_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_HIGH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

    localparam logic              MODE_MEAN   = 1'b0;
    localparam logic              MODE_MEDIAN = 1'b1;
    localparam logic [TRIM_W-1:0] TRIM_LOW_RST  = 5'd5;
    localparam logic [TRIM_W-1:0] TRIM_HIGH_RST = 5'd6;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last_sample;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic              mode;
        logic [TRIM_W-1:0] trim_low;
        logic [TRIM_W-1:0] trim_high;
    } cfg_t;

endpackage

@@ rtl/core/stmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module stmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/stmf_front.sv @@
// Front end: sample intake, store writes, block counting and the job queue.
`timescale 1ns / 1ps
module stmf_front #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  stmf_pkg::item_t                  item,
    input  logic                             back_busy,
    output logic                             ram_we,
    output logic [$clog2(MAX_SAMPLES)-1:0]   ram_waddr,
    output logic [stmf_pkg::SAMPLE_W-1:0]    ram_wdata,
    output logic                             job_valid,
    output logic [$clog2(MAX_SAMPLES+1)-1:0] job_count,
    output logic                             job_ovf,
    input  logic                             job_pop
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] q_cnt_mem [2];
    logic          q_ovf_mem [2];
    logic          q_wp_reg, q_rp_reg;
    logic [1:0]    q_fill_reg, q_fill_next;
    logic          accept, room, q_push;
    logic [CW-1:0] cnt_after;
    logic          ovf_after;

    // Hold off intake while a block is queued or being worked on: the store is shared.
    assign full   = back_busy || (q_fill_reg != 2'd0);
    assign accept = push && !full;
    assign room   = count_reg < MAX_CNT;

    assign cnt_after = room ? count_reg + CW'(1) : count_reg;
    assign ovf_after = ovf_reg || !room;
    assign q_push    = accept && item.last_sample;

    assign ram_we    = accept && room;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = item.sample;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            count_next = item.last_sample ? '0 : cnt_after;
            ovf_next   = item.last_sample ? 1'b0 : ovf_after;
        end
    end

    always_comb
    begin
        q_fill_next = q_fill_reg;
        if (q_push && !job_pop)
        begin
            q_fill_next = q_fill_reg + 2'd1;
        end
        else if (!q_push && job_pop)
        begin
            q_fill_next = q_fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            q_wp_reg   <= 1'b0;
            q_rp_reg   <= 1'b0;
            q_fill_reg <= 2'd0;
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            q_fill_reg <= q_fill_next;
            if (q_push)
            begin
                q_wp_reg <= !q_wp_reg;
            end
            if (job_pop)
            begin
                q_rp_reg <= !q_rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_cnt_mem[q_wp_reg] <= cnt_after;
            q_ovf_mem[q_wp_reg] <= ovf_after;
        end
    end

    assign job_valid = q_fill_reg != 2'd0;
    assign job_count = q_cnt_mem[q_rp_reg];
    assign job_ovf   = q_ovf_mem[q_rp_reg];

endmodule

@@ rtl/core/stmf_div.sv @@
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module stmf_div #(
    parameter int NW = 23,
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   shifted, diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= KW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - KW'(1);
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/stmf_back.sv @@
// Back end: rank sweep over the stored block, windowed sum, divide and result register.
`timescale 1ns / 1ps
`include "sorted_trimmed_mean_filter_core_assert.svh"
module stmf_back #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stmf_pkg::cfg_t                   cfg,
    input  logic                             job_valid,
    input  logic [$clog2(MAX_SAMPLES+1)-1:0] job_count,
    input  logic                             job_ovf,
    output logic                             job_pop,
    output logic                             busy,
    output logic [$clog2(MAX_SAMPLES)-1:0]   ram_raddr,
    input  logic [stmf_pkg::SAMPLE_W-1:0]    ram_rdata,
    output logic                             empty,
    input  logic                             pop,
    output stmf_pkg::result_t                result
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int TW = (CW > 6 ? CW : 6) + 1;
    localparam int SW = stmf_pkg::SAMPLE_W + CW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_KEY   = 3'd1;
    localparam logic [2:0] S_KEYW  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] n_reg, i_reg, j_reg, jd_reg, rank_reg, div_reg;
    logic [TW-1:0] lo_reg, hi_reg;
    logic          ovf_reg, pend_reg;
    logic [stmf_pkg::SAMPLE_W-1:0] key_reg, avg_reg;
    logic [stmf_pkg::STATUS_W-1:0] st_reg;
    logic [SW-1:0] sum_reg;
    logic          out_valid_reg;
    stmf_pkg::result_t result_reg;

    logic [TW-1:0] n_ext, tl_ext, th_ext, drop, lo_new, hi_new, rank_ext;
    logic          err_new, less, in_win;
    logic          div_done;
    logic [SW-1:0] quo;

    assign n_ext  = TW'(job_count);
    assign tl_ext = TW'(cfg.trim_low);
    assign th_ext = TW'(cfg.trim_high);
    assign drop   = tl_ext + th_ext;

    always_comb
    begin
        if (cfg.mode == stmf_pkg::MODE_MEDIAN)
        begin
            err_new = job_count == '0;
            lo_new  = (n_ext - TW'(1)) >> 1;
            hi_new  = (n_ext >> 1) + TW'(1);
        end
        else
        begin
            err_new = drop >= n_ext;
            lo_new  = tl_ext;
            hi_new  = n_ext - th_ext;
        end
    end

    assign less     = (ram_rdata < key_reg) || ((ram_rdata == key_reg) && (jd_reg < i_reg));
    assign rank_ext = TW'(rank_reg);
    assign in_win   = (rank_ext >= lo_reg) && (rank_ext < hi_reg);

    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign busy      = state_reg != S_IDLE;
    assign ram_raddr = (state_reg == S_KEY) ? i_reg[AW-1:0] : j_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = err_new ? S_OUT : S_KEY;
                end
            end
            S_KEY:   state_next = S_KEYW;
            S_KEYW:  state_next = S_SWEEP;
            S_SWEEP:
            begin
                if (j_reg == n_reg - CW'(1))
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:  state_next = S_ACC;
            S_ACC:   state_next = (i_reg == n_reg - CW'(1)) ? S_DIV : S_KEY;
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Kick the divider on entry to S_DIV only; the flag below marks that cycle.
    logic div_armed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            div_armed_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= state_reg == S_SWEEP;
            div_armed_reg <= state_reg == S_ACC && state_next == S_DIV;
            if (state_reg == S_OUT && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        jd_reg <= j_reg;
        case (state_reg)
            S_IDLE:
            begin
                n_reg   <= job_count;
                ovf_reg <= job_ovf;
                lo_reg  <= lo_new;
                hi_reg  <= hi_new;
                div_reg <= CW'(hi_new - lo_new);
                i_reg   <= '0;
                sum_reg <= '0;
                avg_reg <= '0;
                st_reg  <= stmf_pkg::ST_EMPTY;
            end
            S_KEYW:
            begin
                key_reg  <= ram_rdata;
                rank_reg <= '0;
                j_reg    <= '0;
            end
            S_SWEEP:
            begin
                j_reg <= j_reg + CW'(1);
            end
            S_ACC:
            begin
                if (in_win)
                begin
                    sum_reg <= sum_reg + SW'(key_reg);
                end
                i_reg <= i_reg + CW'(1);
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    avg_reg <= quo[stmf_pkg::SAMPLE_W-1:0];
                    st_reg  <= ovf_reg ? stmf_pkg::ST_OVF : stmf_pkg::ST_OK;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    result_reg.average <= avg_reg;
                    result_reg.status  <= st_reg;
                end
            end
            default:
            begin
            end
        endcase
        // Count earlier entries in the cycle after their read was issued.
        if (pend_reg && less)
        begin
            rank_reg <= rank_reg + CW'(1);
        end
    end

    stmf_div #(
        .NW(SW),
        .DW(CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_armed_reg),
        .dividend (sum_reg),
        .divisor  (div_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign empty  = !out_valid_reg;
    assign result = result_reg;

    `STMF_ASSERT_IMP(a_rank_in_block, state_reg == S_ACC, rank_reg < n_reg, "rank past block")
    `STMF_ASSERT_IMP(a_div_nonzero, div_armed_reg, div_reg != '0, "divide by zero count")
    `STMF_ASSERT_NXT(a_result_loaded, state_reg == S_OUT && !out_valid_reg, out_valid_reg,
                     "result not loaded")
    `STMF_ASSERT_IMP(a_pop_when_idle, job_pop, state_reg == S_IDLE, "job taken while busy")

endmodule

@@ rtl/core/sorted_trimmed_mean_filter_core.sv @@
// Sorted trimmed-mean filter: top level with configuration registers.
// Intake: one sample transfer per cycle while full is low; full holds from the marked sample until the block is done.
// Time from the marked sample to the result is set by the rank sweep over the one-read-port
//   store and the bit-serial divider; a block with nothing left after trimming skips both and
//   goes straight to the result register.
// Reset: mode 0, trim_low 5, trim_high 6, no block open, result empty; store left undefined.
`timescale 1ns / 1ps
module sorted_trimmed_mean_filter_core #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  stmf_pkg::item_t                    item,
    output logic                               empty,
    input  logic                               pop,
    output stmf_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [stmf_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [stmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);

    stmf_pkg::cfg_t cfg_reg;

    logic          back_busy;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [stmf_pkg::SAMPLE_W-1:0] ram_wdata, ram_rdata;
    logic          job_valid, job_ovf, job_pop;
    logic [CW-1:0] job_count;

    // Configuration: write by index, drop writes to unknown indexes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= stmf_pkg::MODE_MEAN;
            cfg_reg.trim_low  <= stmf_pkg::TRIM_LOW_RST;
            cfg_reg.trim_high <= stmf_pkg::TRIM_HIGH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                stmf_pkg::CFG_MODE:      cfg_reg.mode      <= cfg_data[0];
                stmf_pkg::CFG_TRIM_LOW:  cfg_reg.trim_low  <= cfg_data;
                stmf_pkg::CFG_TRIM_HIGH: cfg_reg.trim_high <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front: count the block, write samples, queue one job per marked sample.
    stmf_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .back_busy (back_busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .job_valid (job_valid),
        .job_count (job_count),
        .job_ovf   (job_ovf),
        .job_pop   (job_pop)
    );

    // Sample store shared by intake writes and rank-sweep reads.
    stmf_ram #(
        .WIDTH(stmf_pkg::SAMPLE_W),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Back: rank each sample, sum the kept window, divide, hold the result for transfer.
    stmf_back #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (job_valid),
        .job_count (job_count),
        .job_ovf   (job_ovf),
        .job_pop   (job_pop),
        .busy      (back_busy),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
